>>> sv/cdxp_pkg.sv
// shared types, constants and helper functions for the column delta xor predictor
package cdxp_pkg;

  localparam int COLUMNS_DEFAULT = 64;

  localparam int SAMPLE_W = 16;
  localparam int COLUMN_W = 6;
  localparam int ROW_W    = 16;
  localparam int HIST_W   = 32;
  localparam int HALF_W   = 4;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic REG_PREDICT_MODE   = 1'b0;
  localparam logic REG_JUMP_THRESHOLD = 1'b1;

  localparam logic [SAMPLE_W-1:0] JUMP_THRESHOLD_RESET = 16'd256;

  typedef struct packed {
    logic [HIST_W-1:0]   hist;
    logic [SAMPLE_W-1:0] jump;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_CALC,
    S_DONE
  } state_t;

  // ceil(bitlen(v) / 2)
  function automatic logic [HALF_W-1:0] half_length(input logic [SAMPLE_W-1:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < SAMPLE_W; i++) begin
      if (v[i]) begin
        n = 5'(i + 1);
      end
    end
    return HALF_W'((n + 5'd1) >> 1);
  endfunction

endpackage

>>> sv/cdxp_column_ram.sv
// per-column state memory (history and jump words) with a clearing sweep after reset
module cdxp_column_ram import cdxp_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEFAULT
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       rd_en,
  input  logic [((COLUMNS > 1) ? $clog2(COLUMNS) : 1)-1:0] rd_addr,
  output entry_t                                     rd_data,
  input  logic                                       wr_en,
  input  logic [((COLUMNS > 1) ? $clog2(COLUMNS) : 1)-1:0] wr_addr,
  input  entry_t                                     wr_data,
  output logic                                       ready
);

  localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  entry_t mem [COLUMNS];
  entry_t rd_data_r;

  logic [AW-1:0] clr_cnt_r;
  logic          clearing_r;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  entry_t        mem_wd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      if (clr_cnt_r == AW'(COLUMNS - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_comb begin
    if (clearing_r) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = '0;
    end else begin
      mem_we = wr_en;
      mem_wa = wr_addr;
      mem_wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign ready   = !clearing_r;

endmodule

>>> sv/cdxp_divider.sv
// 32 by 16 restoring divider, one quotient bit per cycle, quotient saturated to 16 bits
module cdxp_divider import cdxp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [HIST_W-1:0]   dividend,
  input  logic [SAMPLE_W-1:0] divisor,
  output logic                busy,
  output logic                done,
  output logic [SAMPLE_W-1:0] quotient
);

  logic                busy_r;
  logic                done_r;
  logic [3:0]          cnt_r;
  logic [SAMPLE_W-1:0] rem_r;
  logic [SAMPLE_W-1:0] quo_r;
  logic [SAMPLE_W-1:0] den_r;

  logic [SAMPLE_W:0]   trial;
  logic                ge;

  assign trial = {rem_r, quo_r[SAMPLE_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // high half not below the divisor means the quotient overflows 16 bits
        if (dividend[HIST_W-1:SAMPLE_W] >= divisor) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r && cnt_r == 4'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= divisor;
      cnt_r <= 4'd15;
      if (dividend[HIST_W-1:SAMPLE_W] >= divisor) begin
        quo_r <= '1;
      end else begin
        rem_r <= dividend[HIST_W-1:SAMPLE_W];
        quo_r <= dividend[SAMPLE_W-1:0];
      end
    end else if (busy_r) begin
      // remainder stays below the divisor, so the difference fits 16 bits
      rem_r <= ge ? SAMPLE_W'(trial - {1'b0, den_r}) : trial[SAMPLE_W-1:0];
      quo_r <= {quo_r[SAMPLE_W-2:0], ge};
      cnt_r <= cnt_r - 4'd1;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> sv/column_delta_xor_predictor.sv
// top level: per-column delta predictor with xor jump coding
//
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    tdata: sample, column, row_index
//  out_     out  out_tvalid/out_tready  tdata: residual, negative, half_bits
//  cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// one item at a time: a seeding row or an out of range column goes from idle straight to done,
// previous-value mode passes through read and calc, and mean mode also waits in div on the
// bit-serial divider, which skips its bit loop on overflow.
// after reset the column memory is swept clear; in_tready is low then.
// the output register lets the next item be taken while a result waits;
// a stalled output only holds the item after that in its final state.
module column_delta_xor_predictor import cdxp_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // sample[15:0], column[21:16], row_index[37:22]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // residual[15:0], negative[16], half_bits[20:17]
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  // configuration
  logic                predict_mode_r;
  logic [SAMPLE_W-1:0] jump_threshold_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      predict_mode_r   <= 1'b0;
      jump_threshold_r <= JUMP_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PREDICT_MODE:   predict_mode_r   <= cfg_data[0];
        REG_JUMP_THRESHOLD: jump_threshold_r <= cfg_data;
        default:            ;
      endcase
    end
  end

  // input fields
  logic [SAMPLE_W-1:0] in_sample;
  logic [COLUMN_W-1:0] in_column;
  logic [ROW_W-1:0]    in_row;
  logic                in_col_ok;
  logic                in_pass;
  logic                in_accept;

  assign in_sample = in_tdata[15:0];
  assign in_column = in_tdata[21:16];
  assign in_row    = in_tdata[37:22];
  assign in_col_ok = 32'(in_column) < COLUMNS;
  assign in_pass   = (in_row == '0) || !in_col_ok;
  assign in_accept = in_tvalid && in_tready;

  state_t state_r, state_nxt;

  logic [SAMPLE_W-1:0] samp_r;
  logic [AW-1:0]       col_r;
  logic [ROW_W-1:0]    row_r;
  logic [HIST_W-1:0]   hist_r;
  logic [SAMPLE_W-1:0] jump_r;
  logic [SAMPLE_W-1:0] pred_r;
  logic [SAMPLE_W-1:0] res_r;
  logic                neg_r;

  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_res_r;
  logic                out_neg_r;
  logic [HALF_W-1:0]   out_half_r;

  // memory and divider hookup
  logic          ram_rd_en;
  entry_t        ram_rd_data;
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  entry_t        ram_wr_data;
  logic          ram_ready;

  logic                div_start;
  logic                div_busy;
  logic                div_done;
  logic [SAMPLE_W-1:0] div_q;

  logic                calc_neg;
  logic [SAMPLE_W-1:0] calc_mag;
  logic                out_load;

  assign calc_neg = samp_r < pred_r;
  assign calc_mag = calc_neg ? (pred_r - samp_r) : (samp_r - pred_r);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  cdxp_column_ram #(
    .COLUMNS(COLUMNS)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (ram_rd_en),
    .rd_addr (AW'(in_column)),
    .rd_data (ram_rd_data),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .ready   (ram_ready)
  );

  cdxp_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ram_rd_data.hist),
    .divisor  (row_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // the write of one item lands before the next item can issue its read,
  // so same-column items need no forwarding
  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    ram_rd_en   = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = col_r;
    ram_wr_data = '0;
    div_start   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = ram_ready;
        if (in_accept) begin
          if (in_pass) begin
            // seeding row: history takes the sample, jump word clears; an out of range column writes nothing
            ram_wr_en        = in_col_ok;
            ram_wr_addr      = AW'(in_column);
            ram_wr_data.hist = HIST_W'(in_sample);
            ram_wr_data.jump = '0;
            state_nxt        = S_DONE;
          end else begin
            ram_rd_en = 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        div_start = predict_mode_r;
        state_nxt = predict_mode_r ? S_DIV : S_CALC;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        ram_wr_en        = 1'b1;
        ram_wr_addr      = col_r;
        ram_wr_data.hist = predict_mode_r ? (hist_r + HIST_W'(samp_r)) : HIST_W'(samp_r);
        ram_wr_data.jump = (calc_mag < jump_threshold_r) ? calc_mag : jump_r;
        state_nxt        = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          samp_r <= in_sample;
          col_r  <= AW'(in_column);
          row_r  <= in_row;
          res_r  <= in_sample;
          neg_r  <= 1'b0;
        end
      end
      S_READ: begin
        hist_r <= ram_rd_data.hist;
        jump_r <= ram_rd_data.jump;
        pred_r <= ram_rd_data.hist[SAMPLE_W-1:0];
      end
      S_DIV: begin
        if (div_done) begin
          pred_r <= div_q;
        end
      end
      S_CALC: begin
        res_r <= jump_r ^ calc_mag;
        neg_r <= calc_neg;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r  <= res_r;
      out_neg_r  <= neg_r;
      out_half_r <= half_length(res_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_half_r, out_neg_r, out_res_r};

  // no item is taken while the memory sweep runs
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !ram_ready |-> !in_tready)
    else $error("input accepted during memory clear");

  // the divider is working or finishing whenever the controller waits on it
  a_div_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_busy || div_done))
    else $error("waiting on an idle divider");

  // a read is issued only from idle and is followed by the capture state
  a_read_then_capture: assert property (@(posedge clk) disable iff (!rst_n)
    ram_rd_en |=> (state_r == S_READ))
    else $error("memory read data not captured");

  // the half length of a 16-bit word never exceeds eight
  a_half_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[20:17] <= 4'd8))
    else $error("half_bits out of range");

endmodule

>>> test/tb_column_delta_xor_predictor.sv
// testbench for the column delta xor predictor: random and directed beats checked by a scoreboard
module tb_column_delta_xor_predictor;
  import cdxp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_PREVIOUS = 1'b0;
  localparam logic MODE_MEAN     = 1'b1;
  localparam int   STALL_LIMIT   = 4000;
  localparam int   BATCH_ITEMS   = 145;

  typedef struct packed {
    logic [SAMPLE_W-1:0] residual;
    logic                negative;
    logic [HALF_W-1:0]   half_bits;
  } coded_t;

  class residual_scoreboard;
    logic [HIST_W-1:0]   history [COLUMNS_DEFAULT];
    logic [SAMPLE_W-1:0] jump_word [COLUMNS_DEFAULT];
    logic                mean_mode;
    logic [SAMPLE_W-1:0] threshold;
    coded_t              expected_codes [$];
    int                  errors;

    function new();
      for (int i = 0; i < COLUMNS_DEFAULT; i++) begin
        history[i]   = '0;
        jump_word[i] = '0;
      end
      mean_mode = MODE_PREVIOUS;
      threshold = JUMP_THRESHOLD_RESET;
      errors    = 0;
    endfunction

    function automatic logic [HALF_W-1:0] half_bit_length(logic [SAMPLE_W-1:0] v);
      logic [SAMPLE_W-1:0] t;
      int n;
      t = v;
      n = 0;
      while (t != 0) begin
        t = t >> 1;
        n++;
      end
      return HALF_W'((n + 1) / 2);
    endfunction

    function void set_reg(logic idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_PREDICT_MODE) begin
        mean_mode = value[0];
      end else begin
        threshold = value;
      end
    endfunction

    function void note_input(logic [SAMPLE_W-1:0] smp, logic [COLUMN_W-1:0] col,
                             logic [ROW_W-1:0] row);
      coded_t              c;
      logic [HIST_W-1:0]   quot;
      logic [SAMPLE_W-1:0] pred;
      logic [SAMPLE_W-1:0] mag;
      if (row == 0) begin
        history[col]   = {16'd0, smp};
        jump_word[col] = '0;
        c.residual     = smp;
        c.negative     = 1'b0;
      end else begin
        if (mean_mode == MODE_MEAN) begin
          quot = history[col] / {16'd0, row};
          pred = (quot > 32'h0000_FFFF) ? 16'hFFFF : quot[SAMPLE_W-1:0];
        end else begin
          pred = history[col][SAMPLE_W-1:0];
        end
        c.negative = (smp < pred);
        mag        = c.negative ? (pred - smp) : (smp - pred);
        c.residual = jump_word[col] ^ mag;
        if (mag < threshold) begin
          jump_word[col] = mag;
        end
        if (mean_mode == MODE_MEAN) begin
          history[col] = history[col] + {16'd0, smp};
        end else begin
          history[col] = {16'd0, smp};
        end
      end
      c.half_bits = half_bit_length(c.residual);
      expected_codes.insert(expected_codes.size(), c);
    endfunction

    function void check_output(logic [OUT_TDATA_W-1:0] d);
      coded_t got;
      coded_t want;
      got = {d[15:0], d[16], d[20:17]};
      if (expected_codes.size() == 0) begin
        $error("result beat with no expectation: residual %0d", got.residual);
        errors++;
      end else begin
        want = expected_codes.pop_front();
        if (got.residual !== want.residual) begin
          $error("residual: expected %0d, actual %0d", want.residual, got.residual);
          errors++;
        end
        if (got.negative !== want.negative) begin
          $error("negative: expected %0d, actual %0d", want.negative, got.negative);
          errors++;
        end
        if (got.half_bits !== want.half_bits) begin
          $error("half_bits: expected %0d, actual %0d", want.half_bits, got.half_bits);
          errors++;
        end
      end
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index  = 1'b0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  residual_scoreboard sb;
  int  tx_idle_pct  = 0;
  int  rx_idle_pct  = 0;
  int  items_sent   = 0;
  int  stall_cycles = 0;
  bit  seeded [COLUMNS_DEFAULT];

  column_delta_xor_predictor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_output(out_tdata);
    end
  end

  // cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL column_delta_xor_predictor");
      $finish;
    end
  end

  task automatic send_item(logic [SAMPLE_W-1:0] smp, logic [COLUMN_W-1:0] col,
                           logic [ROW_W-1:0] row);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, row, col, smp};
    do @(posedge clk); while (!in_tready);
    sb.note_input(smp, col, row);
    if (row == 0) begin
      seeded[col] = 1'b1;
    end
    items_sent++;
  endtask

  task automatic cfg_write(logic idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, value);
  endtask

  // registers change only once every result is back
  task automatic apply_settings(logic mode, logic [CFG_DATA_W-1:0] thr);
    in_tvalid <= 1'b0;
    while (sb.expected_codes.size() != 0) @(posedge clk);
    cfg_write(REG_PREDICT_MODE, {15'd0, mode});
    cfg_write(REG_JUMP_THRESHOLD, thr);
    cfg_valid <= 1'b0;
  endtask

  // rows 0..n over a few columns, samples wandering around a base
  task automatic run_frame();
    logic [COLUMN_W-1:0] cols [4];
    int base [4];
    int ncols;
    int nrows;
    int spread;
    ncols = $urandom_range(1, 4);
    nrows = $urandom_range(2, 12);
    case ($urandom_range(0, 3))
      0:       spread = 3;
      1:       spread = 40;
      2:       spread = 600;
      default: spread = 5000;
    endcase
    for (int c = 0; c < ncols; c++) begin
      cols[c] = COLUMN_W'($urandom_range(0, COLUMNS_DEFAULT - 1));
      base[c] = int'($urandom_range(0, 65535));
    end
    for (int r = 0; r < nrows; r++) begin
      for (int c = 0; c < ncols; c++) begin
        send_item(SAMPLE_W'(base[c] + int'($urandom_range(0, 2 * spread)) - spread),
                  cols[c], ROW_W'(r));
      end
    end
  endtask

  task automatic run_noise();
    logic [COLUMN_W-1:0] col;
    logic [ROW_W-1:0]    row;
    col = COLUMN_W'($urandom_range(0, COLUMNS_DEFAULT - 1));
    if (!seeded[col]) begin
      row = '0;
    end else begin
      case ($urandom_range(0, 9))
        0:       row = '0;
        1, 2, 3: row = ROW_W'($urandom_range(1, 3));  // small divisor drives the mean into saturation
        default: row = ROW_W'($urandom_range(0, 65535));
      endcase
    end
    send_item(SAMPLE_W'($urandom_range(0, 65535)), col, row);
  endtask

  task automatic run_batch(int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) < 7) begin
        run_frame();
      end else begin
        run_noise();
      end
    end
  endtask

  initial begin
    sb = new();
    for (int i = 0; i < COLUMNS_DEFAULT; i++) begin
      seeded[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 22;
    rx_idle_pct = 61;

    // directed: extremes, jump update, reuse of the jump word
    apply_settings(MODE_PREVIOUS, JUMP_THRESHOLD_RESET);
    send_item(16'd0, 6'd0, 16'd0);
    send_item(16'hFFFF, 6'd63, 16'd0);
    send_item(16'hFFFF, 6'd0, 16'd1);
    send_item(16'd0, 6'd63, 16'hFFFF);
    send_item(16'd65530, 6'd0, 16'd2);
    send_item(16'd65533, 6'd0, 16'd3);
    send_item(16'd1000, 6'd5, 16'd0);
    send_item(16'd1000, 6'd5, 16'd1);

    // mean mode: saturated quotient, largest row, history left in previous form
    apply_settings(MODE_MEAN, 16'hFFFF);
    send_item(16'hFFFF, 6'd1, 16'd0);
    send_item(16'hFFFF, 6'd1, 16'd1);
    send_item(16'hFFFF, 6'd1, 16'd1);
    send_item(16'd0, 6'd1, 16'hFFFF);
    send_item(16'd0, 6'd0, 16'd4);
    send_item(16'd12345, 6'd63, 16'd0);
    send_item(16'd12000, 6'd63, 16'd1);

    // previous mode reading a history word written as a running sum
    apply_settings(MODE_PREVIOUS, 16'd0);
    send_item(16'd100, 6'd1, 16'd5);
    send_item(16'd1001, 6'd5, 16'd2);
    send_item(16'd1001, 6'd5, 16'd3);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 22;
          rx_idle_pct = 61;
        end
        1: begin
          tx_idle_pct = 61;
          rx_idle_pct = 22;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < 4; k++) begin
        case (k)
          0:       apply_settings(MODE_PREVIOUS, 16'd0);
          1:       apply_settings(MODE_MEAN, 16'hFFFF);
          2:       apply_settings(MODE_PREVIOUS, CFG_DATA_W'($urandom_range(1, 2000)));
          default: apply_settings(MODE_MEAN, CFG_DATA_W'($urandom_range(1, 700)));
        endcase
        run_batch(BATCH_ITEMS);
      end
    end

    in_tvalid <= 1'b0;
    while (sb.expected_codes.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (sb.expected_codes.size() != 0) begin
      $error("%0d expected results never arrived", sb.expected_codes.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASS column_delta_xor_predictor");
    end else begin
      $display("FAIL column_delta_xor_predictor");
    end
    $finish;
  end

endmodule
